@@ rtl/qtl_pkg.sv @@
// Shared types and constants of the quoted token lexer.
package qtl_pkg;

  // Lexer modes.
  typedef enum logic [2:0] {
    MODE_BETWEEN    = 3'd0,
    MODE_BARE       = 3'd1,
    MODE_STRING     = 3'd2,
    MODE_ESC        = 3'd3,
    MODE_OCTAL      = 3'd4,
    MODE_HEX_START  = 3'd5,
    MODE_HEX_DIGITS = 3'd6,
    MODE_ERROR      = 3'd7
  } mode_t;

  // Kind of a result beat.
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  // Line status reported with the line-done beat.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNMATCHED   = 3'd1,
    ST_DANGLING    = 3'd2,
    ST_OCTAL_RANGE = 3'd3,
    ST_NO_HEX      = 3'd4,
    ST_BAD_ESCAPE  = 3'd5
  } status_t;

  // Input function codes.
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_EOL  = 1'b1;

  // Characters of interest.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [9:0] OCT_MAX   = 10'd255;

  // One input beat.
  typedef struct packed {
    logic       func;
    logic [7:0] char_in;
  } item_t;

  // One result beat.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_out;
    status_t    status;
    logic       last;
  } res_t;

  // What one input item produces: one or two result beats.
  typedef struct packed {
    logic pair;
    res_t r0;
    res_t r1;
  } entry_t;

endpackage

@@ rtl/qtl_front.sv @@
// Front end: accepts bytes, runs the lexer state and forms the result entries.
module qtl_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  qtl_pkg::item_t item,
  output logic           q_push,
  output qtl_pkg::entry_t q_entry,
  input  logic           q_full
);
  import qtl_pkg::*;

  mode_t      mode, mode_next;
  logic       quote_is_double, quote_is_double_next;
  logic [9:0] escape_value, escape_value_next;
  logic [1:0] digit_count, digit_count_next;
  status_t    line_status, line_status_next;

  logic       accept;
  logic [7:0] c;
  logic       is_ws, is_dec, is_quote, is_delim, is_bslash;
  logic       hex_ok, simple_ok;
  logic [3:0] hex_v;
  logic [7:0] simple_v;
  logic [9:0] oct_new, hex_new;
  logic [1:0] n;
  res_t       r0, r1;

  function automatic res_t mk(kind_t k, logic [7:0] ch, status_t st);
    res_t r;
    r.kind     = k;
    r.char_out = ch;
    r.status   = st;
    r.last     = 1'b0;
    return r;
  endfunction

  // The first error of a line wins.
  function automatic status_t merged(status_t cur, status_t code);
    return (cur != ST_OK) ? cur : code;
  endfunction

  assign full   = q_full;
  assign accept = push && !q_full;
  assign c      = item.char_in;

  // Byte classification.
  assign is_ws     = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign is_dec    = (c >= "0") && (c <= "9");
  assign is_quote  = (c == CH_DQUOTE) || (c == CH_SQUOTE);
  assign is_delim  = (c == (quote_is_double ? CH_DQUOTE : CH_SQUOTE));
  assign is_bslash = (c == CH_BSLASH);

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = c[3:0];
    if (is_dec) begin
      hex_v = c[3:0];
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      hex_v = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    simple_ok = 1'b1;
    case (c)
      "n":       simple_v = 8'h0A;
      "r":       simple_v = 8'h0D;
      "t":       simple_v = 8'h09;
      "b":       simple_v = 8'h08;
      "f":       simple_v = 8'h0C;
      "v":       simple_v = 8'h0B;
      CH_BSLASH: simple_v = CH_BSLASH;
      CH_SQUOTE: simple_v = CH_SQUOTE;
      "?":       simple_v = "?";
      CH_DQUOTE: simple_v = CH_DQUOTE;
      default: begin
        simple_ok = 1'b0;
        simple_v  = 8'h00;
      end
    endcase
  end

  // Escape accumulation; the stored value keeps ten bits.
  assign oct_new = {escape_value[6:0], 3'b000} + {6'd0, c[3:0]};
  assign hex_new = {escape_value[5:0], 4'b0000} + {6'd0, hex_v};

  // Next state.
  always_comb begin
    mode_next            = mode;
    quote_is_double_next = quote_is_double;
    escape_value_next    = escape_value;
    digit_count_next     = digit_count;
    line_status_next     = line_status;
    if (item.func == FUNC_EOL) begin
      mode_next            = MODE_BETWEEN;
      quote_is_double_next = 1'b0;
      escape_value_next    = '0;
      digit_count_next     = '0;
      line_status_next     = ST_OK;
    end else begin
      case (mode)
        MODE_BETWEEN: begin
          if (is_ws) begin
            mode_next = MODE_BETWEEN;
          end else if (is_quote) begin
            quote_is_double_next = (c == CH_DQUOTE);
            mode_next            = MODE_STRING;
          end else begin
            mode_next = MODE_BARE;
          end
        end
        MODE_BARE: begin
          if (is_ws) mode_next = MODE_BETWEEN;
        end
        MODE_STRING: begin
          if (is_delim) mode_next = MODE_BETWEEN;
          else if (is_bslash) mode_next = MODE_ESC;
        end
        MODE_ESC: begin
          if (simple_ok) begin
            mode_next = MODE_STRING;
          end else if (is_dec) begin
            escape_value_next = {6'd0, c[3:0]};
            digit_count_next  = 2'd1;
            mode_next         = MODE_OCTAL;
          end else if (c == CH_X) begin
            escape_value_next = '0;
            digit_count_next  = '0;
            mode_next         = MODE_HEX_START;
          end else begin
            line_status_next = merged(line_status, ST_BAD_ESCAPE);
            mode_next        = MODE_ERROR;
          end
        end
        MODE_OCTAL: begin
          if (is_dec) begin
            escape_value_next = oct_new;
            digit_count_next  = digit_count + 2'd1;
            if (digit_count == 2'd2) begin
              if (oct_new > OCT_MAX) begin
                line_status_next = merged(line_status, ST_OCTAL_RANGE);
                mode_next        = MODE_ERROR;
              end else begin
                mode_next = MODE_STRING;
              end
            end
          end else if (is_delim) begin
            mode_next = MODE_BETWEEN;
          end else if (is_bslash) begin
            mode_next = MODE_ESC;
          end else begin
            mode_next = MODE_STRING;
          end
        end
        MODE_HEX_START: begin
          if (hex_ok) begin
            escape_value_next = {6'd0, hex_v};
            digit_count_next  = 2'd1;
            mode_next         = MODE_HEX_DIGITS;
          end else begin
            line_status_next = merged(line_status, ST_NO_HEX);
            mode_next        = MODE_ERROR;
          end
        end
        MODE_HEX_DIGITS: begin
          if (hex_ok) begin
            escape_value_next = hex_new;
            mode_next         = MODE_STRING;
          end else if (is_delim) begin
            mode_next = MODE_BETWEEN;
          end else if (is_bslash) begin
            mode_next = MODE_ESC;
          end else begin
            mode_next = MODE_STRING;
          end
        end
        default: mode_next = mode;
      endcase
    end
  end

  // Results caused by the current byte.
  always_comb begin
    n  = 2'd0;
    r0 = mk(KIND_CHAR, 8'h00, ST_OK);
    r1 = mk(KIND_CHAR, 8'h00, ST_OK);
    if (item.func == FUNC_EOL) begin
      case (mode)
        MODE_BARE: begin
          n  = 2'd2;
          r0 = mk(KIND_END, 8'h00, ST_OK);
          r1 = mk(KIND_DONE, 8'h00, line_status);
        end
        MODE_STRING: begin
          n  = 2'd1;
          r0 = mk(KIND_DONE, 8'h00, merged(line_status, ST_UNMATCHED));
        end
        MODE_ESC: begin
          n  = 2'd1;
          r0 = mk(KIND_DONE, 8'h00, merged(line_status, ST_DANGLING));
        end
        MODE_OCTAL, MODE_HEX_DIGITS: begin
          n  = 2'd2;
          r0 = mk(KIND_CHAR, escape_value[7:0], ST_OK);
          r1 = mk(KIND_DONE, 8'h00, merged(line_status, ST_UNMATCHED));
        end
        MODE_HEX_START: begin
          n  = 2'd1;
          r0 = mk(KIND_DONE, 8'h00, merged(line_status, ST_NO_HEX));
        end
        default: begin
          n  = 2'd1;
          r0 = mk(KIND_DONE, 8'h00, line_status);
        end
      endcase
    end else begin
      case (mode)
        MODE_BETWEEN: begin
          if (!is_ws && !is_quote) begin
            n  = 2'd1;
            r0 = mk(KIND_CHAR, c, ST_OK);
          end
        end
        MODE_BARE: begin
          n  = 2'd1;
          r0 = is_ws ? mk(KIND_END, 8'h00, ST_OK) : mk(KIND_CHAR, c, ST_OK);
        end
        MODE_STRING: begin
          if (is_delim) begin
            n  = 2'd1;
            r0 = mk(KIND_END, 8'h00, ST_OK);
          end else if (!is_bslash) begin
            n  = 2'd1;
            r0 = mk(KIND_CHAR, c, ST_OK);
          end
        end
        MODE_ESC: begin
          if (simple_ok) begin
            n  = 2'd1;
            r0 = mk(KIND_CHAR, simple_v, ST_OK);
          end
        end
        MODE_OCTAL, MODE_HEX_DIGITS: begin
          if ((mode == MODE_OCTAL) ? is_dec : hex_ok) begin
            // A completed escape gives its character.
            if (mode == MODE_HEX_DIGITS) begin
              n  = 2'd1;
              r0 = mk(KIND_CHAR, hex_new[7:0], ST_OK);
            end else if (digit_count == 2'd2 && oct_new <= OCT_MAX) begin
              n  = 2'd1;
              r0 = mk(KIND_CHAR, oct_new[7:0], ST_OK);
            end
          end else begin
            // A short escape ends, then the byte counts as string text.
            r0 = mk(KIND_CHAR, escape_value[7:0], ST_OK);
            if (is_delim) begin
              n  = 2'd2;
              r1 = mk(KIND_END, 8'h00, ST_OK);
            end else if (is_bslash) begin
              n  = 2'd1;
            end else begin
              n  = 2'd2;
              r1 = mk(KIND_CHAR, c, ST_OK);
            end
          end
        end
        default: n = 2'd0;
      endcase
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign q_push        = accept && (n != 2'd0);
  assign q_entry.pair  = (n == 2'd2);
  assign q_entry.r0    = r0;
  assign q_entry.r1    = r1;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_BETWEEN;
      quote_is_double <= 1'b0;
      escape_value    <= '0;
      digit_count     <= '0;
      line_status     <= ST_OK;
    end else if (accept) begin
      mode            <= mode_next;
      quote_is_double <= quote_is_double_next;
      escape_value    <= escape_value_next;
      digit_count     <= digit_count_next;
      line_status     <= line_status_next;
    end
  end

  // A line end always yields an entry that closes with line done.
  assert property (@(posedge clk) disable iff (rst)
    (accept && item.func == FUNC_EOL) |->
      (q_push && (q_entry.pair ? q_entry.r1.kind : q_entry.r0.kind) == KIND_DONE))
    else $error("line end without line-done beat");

  // The error mode is left only by a line end.
  assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ERROR && !(accept && item.func == FUNC_EOL)) |=> (mode == MODE_ERROR))
    else $error("error mode left before line end");

endmodule

@@ rtl/qtl_queue.sv @@
// Short queue of result entries between the front and back ends.
module qtl_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qtl_pkg::entry_t wdata,
  output logic            full,
  input  logic            take,
  output qtl_pkg::entry_t rdata,
  output logic            nonempty
);
  import qtl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          store [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_take;

  function automatic logic [AW-1:0] bump(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_take  = take && nonempty;
  assign rdata    = store[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= wdata;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_take) rd_ptr <= bump(rd_ptr);
      count <= count + CW'(do_push) - CW'(do_take);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

endmodule

@@ rtl/qtl_back.sv @@
// Back end: unpacks queued entries into single result beats.
module qtl_back (
  input  logic            clk,
  input  logic            rst,
  input  qtl_pkg::entry_t q_entry,
  input  logic            q_nonempty,
  output logic            q_take,
  output logic            empty,
  input  logic            pop,
  output qtl_pkg::res_t   result
);
  import qtl_pkg::*;

  entry_t cur;
  logic   valid;
  logic   idx;
  logic   done, step;

  assign done   = valid && pop && (idx || !cur.pair);
  assign step   = valid && pop && !idx && cur.pair;
  assign q_take = q_nonempty && (!valid || done);
  assign empty  = !valid;
  assign result = idx ? cur.r1 : cur.r0;

  // Held entry; its payload needs no reset.
  always_ff @(posedge clk) begin
    if (q_take) cur <= q_entry;
  end

  // Occupancy and beat index within the entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 1'b0;
    end else begin
      if (q_take) begin
        valid <= 1'b1;
        idx   <= 1'b0;
      end else if (done) begin
        valid <= 1'b0;
        idx   <= 1'b0;
      end else if (step) begin
        idx <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) idx |-> (valid && cur.pair))
    else $error("second beat of a single-beat entry");

endmodule

@@ rtl/quoted_token_lexer.sv @@
// Top level of the quoted token lexer: front end, entry queue and back end.
//
//   channel   direction  handshake            payload
//   item      in         push / full          func, char_in
//   result    out        pop / empty          kind, char_out, status, last
//
// One byte is taken per cycle while full is low; the front end updates the
// lexer state in the accepting cycle and queues the zero, one or two result
// beats it causes. The back end gives one result beat per cycle while pop is
// high, so an item with two beats holds the output for both; the queue of QUEUE_DEPTH entries absorbs it.
// Reset (rst, synchronous) empties the queue and returns the lexer to the
// between-tokens mode. full rises only when the queue holds QUEUE_DEPTH
// entries; a stalled result never blocks input until then.
module quoted_token_lexer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  qtl_pkg::item_t item,
  output logic           empty,
  input  logic           pop,
  output qtl_pkg::res_t  result
);
  import qtl_pkg::*;

  entry_t f_entry, q_head;
  logic   f_push, q_full, q_nonempty, q_take;

  qtl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_push  (f_push),
    .q_entry (f_entry),
    .q_full  (q_full)
  );

  qtl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .wdata    (f_entry),
    .full     (q_full),
    .take     (q_take),
    .rdata    (q_head),
    .nonempty (q_nonempty)
  );

  qtl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_entry    (q_head),
    .q_nonempty (q_nonempty),
    .q_take     (q_take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
